// ===== design/pvpc_pkg.sv =====
// Shared types, constants and tables of the phase vocoder peak combiner.
// No dependencies.
package pvpc_pkg;

  localparam int unsigned NUM_BINS   = 2048;
  localparam int unsigned ADDR_W     = $clog2(NUM_BINS);
  localparam int unsigned PH_W       = 16;
  localparam int unsigned IN_W       = 24;
  localparam int unsigned MAG_W      = 24;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned LSUM_W     = 32;
  localparam int unsigned WSUM_W     = 56;
  localparam int unsigned BW_W       = 18;
  localparam int unsigned NUM_W      = ADDR_W + PH_W;
  localparam int unsigned FRAW_W     = NUM_W + BW_W + 1 - (PH_W + 8);
  localparam int unsigned CORDIC_W   = 35;
  localparam int unsigned ANG_W      = 32;
  localparam int unsigned CORDIC_STEPS = 28;
  localparam int unsigned SQRT_STEPS = MAG_W;
  localparam int unsigned DIV_STEPS  = FREQ_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_W      = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_WIDTH = 3'd0,
    REG_FIRST_BIN = 3'd1,
    REG_BIN_LIMIT = 3'd2,
    REG_MIN_FREQ  = 3'd3,
    REG_MAX_FREQ  = 3'd4,
    REG_LEVEL_THR = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              load_in;
    logic              sq;
    logic              init;
    logic              step;
    logic              wr_phase;
    logic              fmul;
    logic              mulmag;
    logic              emit;
    logic              emit_last;
    logic              run_clear;
    logic              run_update;
    logic              div_init;
    logic              div_step;
    logic              clr_wr;
    logic [ADDR_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic bin_ok;
    logic fend;
    logic pass;
    logic mismatch;
    logic run_open;
    logic out_busy;
  } sts_t;

  // atan(2^-i) in 2^-32 turns
  function automatic logic [ANG_W-1:0] turn_angle(input logic [4:0] i);
    logic [ANG_W-1:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/phase_vocoder_peak_combiner_unit.sv =====
// Phase vocoder peak combiner, top level.
// Depends on pvpc_pkg, pvpc_ctrl, pvpc_dp.
//
// Takes FFT bins one request at a time and emits merged peak runs. After
// reset the unit clears the stored-phase RAM before the first bin is
// taken. A bin at or above bin_limit (or bin zero) skips the CORDIC; a
// considered bin runs the 28-step CORDIC; a bin that joins a run also
// runs the 16-step mean divider, after closing the previous run if it
// does not match. A full output register stalls the emit of a run. At
// most two runs leave per bin.
module phase_vocoder_peak_combiner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // bin_real[23:0], bin_imag[47:24], bin_index[58:48]
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // run_freq[15:0], run_level[47:16]
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_we_i,
  input  logic [pvpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pvpc_pkg::CFG_W-1:0]     cfg_data_i
);
  import pvpc_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [FREQ_W-1:0] run_freq;
  logic [LSUM_W-1:0] run_level;

  pvpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pvpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .re_i        (s_axis_tdata[IN_W-1:0]),
    .im_i        (s_axis_tdata[2*IN_W-1:IN_W]),
    .k_i         (s_axis_tdata[2*IN_W+ADDR_W-1:2*IN_W]),
    .fend_i      (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_freq_o  (run_freq),
    .out_level_o (run_level),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {run_level, run_freq};

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("run emitted over a pending result");
  a_one_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second bin taken while busy");
  a_flush_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.emit_last) |=> !sts.run_open)
    else $error("run still open after frame flush");
`endif

endmodule

// ===== design/pvpc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pvpc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/pvpc_ctrl.sv =====
// Sequencer of the peak combiner: RAM clear sweep, per-bin step order.
// Depends on pvpc_pkg.
module pvpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pvpc_pkg::sts_t sts_i,
  output pvpc_pkg::cmd_t cmd_o
);
  import pvpc_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR = 13'h0001,
    S_IDLE  = 13'h0002,
    S_SQ    = 13'h0004,
    S_LOAD  = 13'h0008,
    S_ITER  = 13'h0010,
    S_PHASE = 13'h0020,
    S_FMUL  = 13'h0040,
    S_CHECK = 13'h0080,
    S_EMIT  = 13'h0100,
    S_UPD   = 13'h0200,
    S_DIVI  = 13'h0400,
    S_DIVS  = 13'h0800,
    S_FEND  = 13'h1000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(NUM_BINS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = sts_i.bin_ok ? S_LOAD : S_FEND;
      end
      S_LOAD: begin
        cmd_o.init = 1'b1;
        cnt_d      = '0;
        state_d    = S_ITER;
      end
      S_ITER: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(CORDIC_STEPS - 1)) state_d = S_PHASE;
      end
      S_PHASE: begin
        cmd_o.wr_phase = 1'b1;
        state_d        = S_FMUL;
      end
      S_FMUL: begin
        cmd_o.fmul = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.mulmag = 1'b1;
        priority if (!sts_i.pass) state_d = S_FEND;
        else if (sts_i.run_open && sts_i.mismatch) state_d = S_EMIT;
        else state_d = S_UPD;
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.run_clear = 1'b1;
          state_d         = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.run_update = 1'b1;
        state_d          = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(DIV_STEPS - 1)) state_d = S_FEND;
      end
      S_FEND: begin
        if (sts_i.fend && sts_i.run_open) begin
          if (!sts_i.out_busy) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            cmd_o.run_clear = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== design/pvpc_dp.sv =====
// Datapath: CORDIC phase, bit-serial sqrt, frequency refinement, run sums,
// mean divider, config registers and output register. Depends on pvpc_pkg, pvpc_ram.
module pvpc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pvpc_pkg::cmd_t                    cmd_i,
  output pvpc_pkg::sts_t                    sts_o,
  input  logic [pvpc_pkg::IN_W-1:0]         re_i,
  input  logic [pvpc_pkg::IN_W-1:0]         im_i,
  input  logic [pvpc_pkg::ADDR_W-1:0]       k_i,
  input  logic                              fend_i,
  input  logic                              cfg_we_i,
  input  logic [pvpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pvpc_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pvpc_pkg::FREQ_W-1:0]       out_freq_o,
  output logic [pvpc_pkg::LSUM_W-1:0]       out_level_o,
  output logic                              out_last_o
);
  import pvpc_pkg::*;

  // config
  logic [BW_W-1:0]   bw_q;
  logic [ADDR_W:0]   first_q, limit_q;
  logic [FREQ_W-1:0] fmin_q, fmax_q;
  logic [MAG_W-1:0]  thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q    <= BW_W'(48000);
      first_q <= (ADDR_W+1)'(4);
      limit_q <= (ADDR_W+1)'(256);
      fmin_q  <= FREQ_W'(720);
      fmax_q  <= FREQ_W'(48000);
      thr_q   <= MAG_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIN_WIDTH: bw_q    <= cfg_data_i[BW_W-1:0];
        REG_FIRST_BIN: first_q <= cfg_data_i[ADDR_W:0];
        REG_BIN_LIMIT: limit_q <= cfg_data_i[ADDR_W:0];
        REG_MIN_FREQ:  fmin_q  <= cfg_data_i[FREQ_W-1:0];
        REG_MAX_FREQ:  fmax_q  <= cfg_data_i[FREQ_W-1:0];
        REG_LEVEL_THR: thr_q   <= cfg_data_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  logic signed [IN_W-1:0] re_q, im_q;
  logic [ADDR_W-1:0]      k_q;
  logic                   fend_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      re_q   <= re_i;
      im_q   <= im_i;
      k_q    <= k_i;
      fend_q <= fend_i;
    end
  end

  // squares and sqrt
  logic [2*IN_W-1:0]    sqa_q, sqb_q, rad_q;
  logic [MAG_W+1:0]     srem_q;
  logic [MAG_W-1:0]     mag_q;
  logic signed [2*IN_W-1:0] re2, im2;
  logic [MAG_W+3:0]     srem_t, strial;

  assign re2    = (2*IN_W)'(re_q) * (2*IN_W)'(re_q);
  assign im2    = (2*IN_W)'(im_q) * (2*IN_W)'(im_q);
  assign srem_t = {srem_q, rad_q[2*IN_W-1 -: 2]};
  assign strial = {2'b00, mag_q, 2'b01};

  // cordic
  logic signed [CORDIC_W-1:0] x_q, y_q, x0, y0, xs, ys;
  logic [ANG_W-1:0]           ang_q;
  logic                       zero_q;

  assign x0 = {{(CORDIC_W-IN_W-8){re_q[IN_W-1]}}, re_q, 8'b0};
  assign y0 = {{(CORDIC_W-IN_W-8){im_q[IN_W-1]}}, im_q, 8'b0};
  assign xs = x_q >>> cmd_i.idx[4:0];
  assign ys = y_q >>> cmd_i.idx[4:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq) begin
      sqa_q <= re2;
      sqb_q <= im2;
    end
    if (cmd_i.init) begin
      rad_q  <= sqa_q + sqb_q;
      srem_q <= '0;
      mag_q  <= '0;
      zero_q <= (re_q == '0) && (im_q == '0);
      if (re_q[IN_W-1]) begin
        x_q   <= -x0;
        y_q   <= -y0;
        ang_q <= ANG_W'(1) << (ANG_W - 1);
      end else begin
        x_q   <= x0;
        y_q   <= y0;
        ang_q <= '0;
      end
    end
    if (cmd_i.step) begin
      if (y_q > 0) begin
        x_q   <= x_q + ys;
        y_q   <= y_q - xs;
        ang_q <= ang_q + turn_angle(cmd_i.idx[4:0]);
      end else begin
        x_q   <= x_q - ys;
        y_q   <= y_q + xs;
        ang_q <= ang_q - turn_angle(cmd_i.idx[4:0]);
      end
      if (cmd_i.idx < ADDR_W'(SQRT_STEPS)) begin
        rad_q <= rad_q << 2;
        if (srem_t >= strial) begin
          srem_q <= (MAG_W+2)'(srem_t - strial);
          mag_q  <= {mag_q[MAG_W-2:0], 1'b1};
        end else begin
          srem_q <= srem_t[MAG_W+1:0];
          mag_q  <= {mag_q[MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  // phase memory
  logic [PH_W-1:0]  prev_ph, ph, raw;
  logic [ANG_W-1:0] ang_r;

  assign ang_r = ang_q + (ANG_W'(1) << (ANG_W - PH_W - 1));
  assign ph    = zero_q ? '0 : ang_r[ANG_W-1 -: PH_W];
  assign raw   = ph - prev_ph - (PH_W'(k_q) << (PH_W - 2));

  pvpc_ram #(.WIDTH(PH_W), .DEPTH(NUM_BINS)) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_wr | cmd_i.wr_phase),
    .waddr_i (cmd_i.clr_wr ? cmd_i.idx : k_q),
    .wdata_i (cmd_i.clr_wr ? '0 : ph),
    .raddr_i (k_q),
    .rdata_o (prev_ph)
  );

  // refined frequency
  logic signed [NUM_W:0]     num_q, num_d;
  logic                      dok_q;
  logic [FRAW_W-1:0]         f_q;
  logic [NUM_W+BW_W:0]       fprod;

  assign num_d = $signed({1'b0, k_q, PH_W'(0)})
               + $signed({{(NUM_W-PH_W-1){raw[PH_W-1]}}, raw, 2'b00});
  assign fprod = (NUM_W+BW_W+1)'(num_q[NUM_W-1:0]) * (NUM_W+BW_W+1)'(bw_q)
               + ((NUM_W+BW_W+1)'(1) << (PH_W + 7));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_phase) begin
      num_q <= num_d;
      dok_q <= (raw[PH_W-1] == raw[PH_W-2]) &&
               !(raw[PH_W-1] && (raw[PH_W-3:0] == '0));
    end
    if (cmd_i.fmul) begin
      f_q <= fprod[NUM_W+BW_W -: FRAW_W];
    end
  end

  // run state
  logic                run_open_q;
  logic [WSUM_W-1:0]   ws_q;
  logic [LSUM_W-1:0]   ls_q;
  logic [FREQ_W-1:0]   mean_q;
  logic [MAG_W+FREQ_W-1:0] magf_q;
  logic [FREQ_W-1:0]   fl, diff;
  logic [FREQ_W+6:0]   lhs, rhs;
  logic [WSUM_W:0]     ws_sum, divn;
  logic [LSUM_W:0]     ls_sum, dtry;
  logic [LSUM_W-1:0]   rem_q;
  logic [FREQ_W-1:0]   low_q;
  logic                hold_q;

  assign fl     = f_q[FREQ_W-1:0];
  assign diff   = (mean_q > fl) ? mean_q - fl : fl - mean_q;
  assign lhs    = (FREQ_W+7)'(diff) * (FREQ_W+7)'(100);
  assign rhs    = (FREQ_W+7)'(fl) * (FREQ_W+7)'(6);
  assign ws_sum = (run_open_q ? {1'b0, ws_q} : '0) + (WSUM_W+1)'(magf_q);
  assign ls_sum = (run_open_q ? {1'b0, ls_q} : '0) + (LSUM_W+1)'(mag_q);
  assign divn   = {1'b0, ws_q} + (WSUM_W+1)'(ls_q >> 1);
  assign dtry   = {rem_q, low_q[FREQ_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mulmag) magf_q <= mag_q * fl;
    if (cmd_i.div_init) begin
      rem_q <= divn[LSUM_W+FREQ_W-1:FREQ_W];
      low_q <= divn[FREQ_W-1:0];
    end
    if (cmd_i.div_step) begin
      low_q <= low_q << 1;
      if (!hold_q) rem_q <= (dtry >= {1'b0, ls_q}) ? LSUM_W'(dtry - {1'b0, ls_q})
                                                   : dtry[LSUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      ws_q       <= '0;
      ls_q       <= '0;
      mean_q     <= '0;
      hold_q     <= 1'b1;
    end else begin
      if (cmd_i.run_clear) begin
        run_open_q <= 1'b0;
        ws_q       <= '0;
        ls_q       <= '0;
        mean_q     <= '0;
      end
      if (cmd_i.run_update) begin
        run_open_q <= 1'b1;
        ws_q       <= ws_sum[WSUM_W] ? '1 : ws_sum[WSUM_W-1:0];
        ls_q       <= ls_sum[LSUM_W] ? '1 : ls_sum[LSUM_W-1:0];
      end
      if (cmd_i.div_init) begin
        priority if (ls_q == '0) begin
          mean_q <= '0;
          hold_q <= 1'b1;
        end else if (divn[WSUM_W:FREQ_W] >= (WSUM_W+1-FREQ_W)'(ls_q)) begin
          mean_q <= '1;
          hold_q <= 1'b1;
        end else begin
          mean_q <= '0;
          hold_q <= 1'b0;
        end
      end
      if (cmd_i.div_step && !hold_q) begin
        mean_q <= {mean_q[FREQ_W-2:0], dtry >= {1'b0, ls_q}};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_freq_o  <= mean_q;
      out_level_o <= ls_q;
      out_last_o  <= cmd_i.emit_last;
    end
  end

  assign sts_o.bin_ok   = (k_q != '0) && ({1'b0, k_q} < limit_q);
  assign sts_o.fend     = fend_q;
  assign sts_o.pass     = ({1'b0, k_q} >= first_q) && (mag_q > thr_q) &&
                          !num_q[NUM_W] && dok_q &&
                          (f_q >= FRAW_W'(fmin_q)) && (f_q <= FRAW_W'(fmax_q));
  assign sts_o.mismatch = !(lhs < rhs);
  assign sts_o.run_open = run_open_q;
  assign sts_o.out_busy = out_valid_o && !out_ready_i;

endmodule
